// ===== rtl/gbp_pkg.sv =====
// ----------------------------------------------------------------------------
// gbp_pkg
// Shared types and constants for the gshare branch predictor with BTB.
// ----------------------------------------------------------------------------
package gbp_pkg;

	localparam int unsigned INDEX_BITS_DEF = 8;
	localparam int unsigned ADDR_W         = 64;
	localparam int unsigned S_DATA_W       = 200;
	localparam int unsigned M_DATA_W       = 72;

	localparam logic REQ_PREDICT = 1'b0;
	localparam logic REQ_UPDATE  = 1'b1;

	localparam logic [1:0] CTR_MIN = 2'd0;
	localparam logic [1:0] CTR_MAX = 2'd3;

	localparam logic [ADDR_W-1:0] FALL_THROUGH = 64'd4;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOK
	} state_t;

	typedef struct packed {
		logic              valid;
		logic              cond;
		logic [ADDR_W-1:0] tag;
		logic [ADDR_W-1:0] target;
	} btb_entry_t;

endpackage

// ===== rtl/gshare_branch_predictor_btb.sv =====
// ----------------------------------------------------------------------------
// gshare_branch_predictor_btb
// Direct-mapped BTB plus gshare direction table, both in synchronous-read RAMs.
// Flow: RAM read registered on the accepting edge; compare, counter update,
//   write-back and the result register follow once the output is free.
// One word in flight: s_tready stays low until the previous result is registered.
// Reset: history cleared; then a clearing pass over all 2**INDEX_BITS entries
//   wipes the BTB valid bits and the counters, with s_tready low during the pass.
// ----------------------------------------------------------------------------
module gshare_branch_predictor_btb #(
	parameter int unsigned INDEX_BITS = gbp_pkg::INDEX_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// pc, actual_target, predicted_target_in, actual_taken,
	// predicted_taken_in, is_conditional, zero pad
	input  logic [gbp_pkg::S_DATA_W-1:0]  s_tdata,
	// req_type
	input  logic [0:0]                    s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// next_address, predict_taken, flush, zero pad
	output logic [gbp_pkg::M_DATA_W-1:0]  m_tdata
);

	localparam int unsigned DEPTH = 2 ** INDEX_BITS;
	localparam int unsigned AW    = gbp_pkg::ADDR_W;

	gbp_pkg::state_t state_q, state_d;

	gbp_pkg::btb_entry_t btb_mem [DEPTH];
	logic [1:0]          pht_mem [DEPTH];

	logic [INDEX_BITS-1:0] hist_q;
	logic [INDEX_BITS-1:0] clr_idx_q;
	logic                  m_valid_q;
	logic [gbp_pkg::M_DATA_W-1:0] m_data_q;

	logic                  req_s1, tkn_s1, ptkn_s1, cond_s1;
	logic [AW-1:0]         pc_s1, tgt_s1, ptgt_s1;
	logic [INDEX_BITS-1:0] pht_idx_s1;
	gbp_pkg::btb_entry_t   btb_rd_s1;
	logic [1:0]            pht_rd_s1;

	logic                  accept, done, clearing, out_free;
	logic [INDEX_BITS-1:0] slot_in, pht_idx_in, slot_s1;
	logic                  btb_we, pht_we;
	logic [INDEX_BITS-1:0] btb_waddr, pht_waddr;
	gbp_pkg::btb_entry_t   btb_wdata;
	logic [1:0]            pht_wdata, ctr_new;
	logic                  hit, taken, flush, is_upd;
	logic [AW-1:0]         next_addr;

	assign out_free   = !m_valid_q || m_tready;
	assign accept     = s_tvalid && s_tready;
	assign slot_in    = s_tdata[INDEX_BITS+1:2];
	assign pht_idx_in = slot_in ^ hist_q;
	assign slot_s1    = pc_s1[INDEX_BITS+1:2];
	assign is_upd     = (req_s1 == gbp_pkg::REQ_UPDATE);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			gbp_pkg::ST_CLEAR: begin
				if (clr_idx_q == INDEX_BITS'(DEPTH - 1)) state_d = gbp_pkg::ST_IDLE;
			end
			gbp_pkg::ST_IDLE: begin
				if (s_tvalid) state_d = gbp_pkg::ST_LOOK;
			end
			gbp_pkg::ST_LOOK: begin
				if (out_free) state_d = gbp_pkg::ST_IDLE;
			end
			default: state_d = gbp_pkg::ST_CLEAR;
		endcase
	end

	// state outputs
	always_comb begin
		s_tready = 1'b0;
		done     = 1'b0;
		clearing = 1'b0;
		case (state_q)
			gbp_pkg::ST_CLEAR: clearing = 1'b1;
			gbp_pkg::ST_IDLE:  s_tready = 1'b1;
			gbp_pkg::ST_LOOK:  done     = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= gbp_pkg::ST_CLEAR;
			clr_idx_q <= '0;
		end else begin
			state_q <= state_d;
			if (clearing) clr_idx_q <= clr_idx_q + INDEX_BITS'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1     <= s_tuser[0];
			pc_s1      <= s_tdata[AW-1:0];
			tgt_s1     <= s_tdata[2*AW-1:AW];
			ptgt_s1    <= s_tdata[3*AW-1:2*AW];
			tkn_s1     <= s_tdata[3*AW];
			ptkn_s1    <= s_tdata[3*AW+1];
			cond_s1    <= s_tdata[3*AW+2];
			pht_idx_s1 <= pht_idx_in;
		end
	end

	// lookup and resolve
	always_comb begin
		hit       = btb_rd_s1.valid && (btb_rd_s1.tag == pc_s1);
		taken     = hit && (!btb_rd_s1.cond || pht_rd_s1[1]);
		next_addr = taken ? btb_rd_s1.target : pc_s1 + gbp_pkg::FALL_THROUGH;
		flush     = (ptgt_s1 != tgt_s1) || (ptkn_s1 != tkn_s1);
		if (tkn_s1) ctr_new = (pht_rd_s1 == gbp_pkg::CTR_MAX) ? pht_rd_s1 : pht_rd_s1 + 2'd1;
		else        ctr_new = (pht_rd_s1 == gbp_pkg::CTR_MIN) ? pht_rd_s1 : pht_rd_s1 - 2'd1;
	end

	// RAM write port: clearing pass or write-back
	always_comb begin
		if (clearing) begin
			btb_we    = 1'b1;
			pht_we    = 1'b1;
			btb_waddr = clr_idx_q;
			pht_waddr = clr_idx_q;
			btb_wdata = '0;
			pht_wdata = gbp_pkg::CTR_MIN;
		end else begin
			btb_we    = done && is_upd;
			pht_we    = done && is_upd && cond_s1;
			btb_waddr = slot_s1;
			pht_waddr = pht_idx_s1;
			btb_wdata = '{valid: 1'b1, cond: cond_s1, tag: pc_s1, target: tgt_s1};
			pht_wdata = ctr_new;
		end
	end

	always_ff @(posedge clk) begin
		if (btb_we) btb_mem[btb_waddr] <= btb_wdata;
		if (accept) btb_rd_s1 <= btb_mem[slot_in];
	end

	always_ff @(posedge clk) begin
		if (pht_we) pht_mem[pht_waddr] <= pht_wdata;
		if (accept) pht_rd_s1 <= pht_mem[pht_idx_in];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '0;
		end else if (done && is_upd && cond_s1) begin
			hist_q <= {hist_q[INDEX_BITS-2:0], tkn_s1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (done) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			if (is_upd) m_data_q <= {6'd0, flush, 1'b0, {AW{1'b0}}};
			else        m_data_q <= {6'd0, 1'b0, taken, next_addr};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

`ifndef NO_ASSERTIONS
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("word accepted while previous one in flight");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!m_tvalid || m_tready))
		else $error("pending result overwritten");

	a_result_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[AW] && m_tdata[AW+1]))
		else $error("result marks both taken and flush");

	a_hist_update: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(hist_q) |-> $past(done && is_upd && cond_s1))
		else $error("history changed without conditional update");

	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !s_tready)
		else $error("input accepted during clearing pass");
`endif

endmodule

// ===== sim/gshare_branch_predictor_btb_tb.sv =====
// ----------------------------------------------------------------------------
// gshare_branch_predictor_btb_tb
// Streams predict and update words into the predictor and checks every result
// word against a cycle-free model of the BTB, counters and global history.
// ----------------------------------------------------------------------------
module gshare_branch_predictor_btb_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned IDX_W    = gbp_pkg::INDEX_BITS_DEF;
	localparam int unsigned TABLE_SZ = 1 << IDX_W;
	localparam int unsigned POOL_SZ  = 24;
	localparam int unsigned RAND_N   = 950;
	localparam int unsigned IDLE_PCT = 37;
	localparam int unsigned STALL_LIMIT = 5000;

	typedef struct {
		logic [gbp_pkg::ADDR_W-1:0] next_addr;
		logic                       taken;
		logic                       flush;
	} answer_t;

	class gshare_board;
		gbp_pkg::btb_entry_t btb [TABLE_SZ];
		logic [1:0]          ctr [TABLE_SZ];
		logic [IDX_W-1:0]    hist;
		answer_t             pending[$];
		int                  errors;

		function new();
			foreach (btb[i]) begin
				btb[i] = '0;
				ctr[i] = gbp_pkg::CTR_MIN;
			end
			hist = '0;
			errors = 0;
		endfunction

		function void note_request(logic kind, logic [gbp_pkg::S_DATA_W-1:0] data);
			logic [gbp_pkg::ADDR_W-1:0] pc, act_tgt, pred_tgt;
			logic                       act_tk, pred_tk, is_cond;
			logic [IDX_W-1:0]           slot, pidx;
			gbp_pkg::btb_entry_t        ent;
			answer_t                    ans;
			pc       = data[63:0];
			act_tgt  = data[127:64];
			pred_tgt = data[191:128];
			act_tk   = data[192];
			pred_tk  = data[193];
			is_cond  = data[194];
			slot = pc[IDX_W+1:2];
			pidx = slot ^ hist;
			ans = '{default: '0};
			if (kind == gbp_pkg::REQ_PREDICT) begin
				ent = btb[slot];
				ans.taken = ent.valid && ent.tag == pc && (!ent.cond || ctr[pidx] > 2'd1);
				ans.next_addr = ans.taken ? ent.target : pc + gbp_pkg::FALL_THROUGH;
			end else begin
				btb[slot] = '{valid: 1'b1, cond: is_cond, tag: pc, target: act_tgt};
				if (is_cond) begin
					if (act_tk) begin
						if (ctr[pidx] != gbp_pkg::CTR_MAX) ctr[pidx] = ctr[pidx] + 2'd1;
					end else begin
						if (ctr[pidx] != gbp_pkg::CTR_MIN) ctr[pidx] = ctr[pidx] - 2'd1;
					end
					hist = {hist[IDX_W-2:0], act_tk};
				end
				ans.flush = (pred_tgt != act_tgt) || (pred_tk != act_tk);
			end
			pending.push_back(ans);
		endfunction

		function void check_answer(logic [gbp_pkg::M_DATA_W-1:0] data);
			answer_t want;
			if (pending.size() == 0) begin
				$error("result word with nothing pending: %h", data);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (data[63:0] !== want.next_addr) begin
				$error("next_address: expected %h, got %h", want.next_addr, data[63:0]);
				errors++;
			end
			if (data[64] !== want.taken) begin
				$error("predict_taken: expected %b, got %b", want.taken, data[64]);
				errors++;
			end
			if (data[65] !== want.flush) begin
				$error("flush: expected %b, got %b", want.flush, data[65]);
				errors++;
			end
		endfunction
	endclass

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         s_tvalid = 1'b0;
	logic                         s_tready;
	logic [gbp_pkg::S_DATA_W-1:0] s_tdata = '0;
	logic [0:0]                   s_tuser = gbp_pkg::REQ_PREDICT;
	logic                         m_tvalid;
	logic                         m_tready = 1'b0;
	logic [gbp_pkg::M_DATA_W-1:0] m_tdata;

	gshare_branch_predictor_btb dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	gshare_board board = new();
	bit          calm = 1'b0;
	int          quiet_cycles = 0;
	logic [gbp_pkg::ADDR_W-1:0] pool_pc [POOL_SZ];
	logic [gbp_pkg::ADDR_W-1:0] pool_tgt [POOL_SZ];

	always #5 clk = ~clk;

	always @(negedge clk) begin
		m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
	end

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			board.note_request(s_tuser[0], s_tdata);
		if (arst_n && m_tvalid && m_tready)
			board.check_answer(m_tdata);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic send_word(input logic kind, input logic [gbp_pkg::ADDR_W-1:0] pc,
			input logic [gbp_pkg::ADDR_W-1:0] act_tgt = '0,
			input logic [gbp_pkg::ADDR_W-1:0] pred_tgt = '0,
			input logic act_tk = 1'b0, input logic pred_tk = 1'b0,
			input logic is_cond = 1'b0);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {5'b0, is_cond, pred_tk, act_tk, pred_tgt, act_tgt, pc};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	initial begin
		logic [gbp_pkg::ADDR_W-1:0] pc, at, pt;
		logic                       tk;
		int unsigned                k;

		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		// misses, wrap of the fall-through address
		send_word(gbp_pkg::REQ_PREDICT, 64'h0);
		send_word(gbp_pkg::REQ_PREDICT, 64'hFFFF_FFFF_FFFF_FFFC);
		send_word(gbp_pkg::REQ_PREDICT, 64'hFFFF_FFFF_FFFF_FFFF);
		// unconditional hit, then same slot with another tag
		send_word(gbp_pkg::REQ_UPDATE, 64'h1000, '1, '1, 1'b1, 1'b1, 1'b0);
		send_word(gbp_pkg::REQ_PREDICT, 64'h1000);
		send_word(gbp_pkg::REQ_PREDICT, 64'h1400);
		send_word(gbp_pkg::REQ_PREDICT, 64'h8000_0000_0000_1000);
		// unconditional not taken with a target mismatch
		send_word(gbp_pkg::REQ_UPDATE, 64'h1000, 64'h2000, 64'h2004, 1'b0, 1'b0, 1'b0);
		send_word(gbp_pkg::REQ_PREDICT, 64'h1000);
		// conditional, top slot: target mismatch only, direction mismatch only
		send_word(gbp_pkg::REQ_UPDATE, '1, 64'h0, 64'h1, 1'b1, 1'b1, 1'b1);
		send_word(gbp_pkg::REQ_PREDICT, '1);
		send_word(gbp_pkg::REQ_UPDATE, '1, 64'h0, 64'h0, 1'b1, 1'b0, 1'b1);
		send_word(gbp_pkg::REQ_PREDICT, '1);
		// taken updates, then not-taken updates, on one BTB slot
		repeat (4) send_word(gbp_pkg::REQ_UPDATE, 64'h2000, 64'h5A5A_A5A5_0F0F_F0F0,
			64'h5A5A_A5A5_0F0F_F0F0, 1'b1, 1'b1, 1'b1);
		send_word(gbp_pkg::REQ_PREDICT, 64'h2000);
		repeat (4) send_word(gbp_pkg::REQ_UPDATE, 64'h2000, 64'h5A5A_A5A5_0F0F_F0F0,
			64'hA5A5_5A5A_F0F0_0F0F, 1'b0, 1'b1, 1'b1);
		send_word(gbp_pkg::REQ_PREDICT, 64'h2000);
		send_word(gbp_pkg::REQ_UPDATE, 64'h0, 64'h0, 64'h0, 1'b0, 1'b0, 1'b1);
		send_word(gbp_pkg::REQ_PREDICT, 64'h0);

		for (int i = 0; i < POOL_SZ; i++) begin
			if (i < 16)
				pool_pc[i] = {$urandom, $urandom};
			else
				pool_pc[i] = pool_pc[i-16] ^ (64'h1 << (IDX_W + 2 + $urandom_range(53)));
			pool_tgt[i] = {$urandom, $urandom};
		end

		for (int n = 0; n < RAND_N; n++) begin
			calm = (n >= 300 && n < 500);
			k  = $urandom_range(POOL_SZ - 1);
			pc = ($urandom_range(99) < 80) ? pool_pc[k] : {$urandom, $urandom};
			if ($urandom_range(1)) begin
				send_word(gbp_pkg::REQ_PREDICT, pc);
			end else begin
				tk = 1'($urandom_range(1));
				at = ($urandom_range(99) < 70) ? pool_tgt[k] : {$urandom, $urandom};
				pt = $urandom_range(1) ? at : {$urandom, $urandom};
				send_word(gbp_pkg::REQ_UPDATE, pc, at, pt, tk,
					($urandom_range(99) < 60) ? tk : ~tk,
					$urandom_range(99) < 75);
			end
		end
		s_tvalid <= 1'b0;
		calm = 1'b0;

		while (board.pending.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (board.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
